FILE: design/mlp_fwd_pkg.sv
// mlp_fwd_pkg: shared types, register map and constants of the mlp forward core
// no dependencies; used by every module of the core by scoped names
`timescale 1ns / 1ps

package mlp_fwd_pkg;

  localparam int VALUE_WIDTH     = 16;
  localparam int FRACTION_BITS   = 12;
  // three products of two values plus a shifted bias, with room to spare
  localparam int ACC_WIDTH       = 2 * VALUE_WIDTH + 3;
  localparam int RND_WIDTH       = ACC_WIDTH - FRACTION_BITS;
  localparam int CFG_DATA_WIDTH  = 64;
  localparam int CFG_INDEX_WIDTH = 3;

  // sigmoid breakpoints and offsets
  localparam int SIG_ONE    = 1 << FRACTION_BITS;
  localparam int SIG_SAT    = 5 * SIG_ONE;
  localparam int SIG_MID    = (19 * SIG_ONE) >> 3;
  localparam int SIG_OFF_HI = (27 * SIG_ONE) >> 5;
  localparam int SIG_OFF_MD = (5 * SIG_ONE) >> 3;
  localparam int SIG_OFF_LO = SIG_ONE >> 1;

  localparam int VAL_MAX = (1 << (VALUE_WIDTH - 1)) - 1;
  localparam int VAL_MIN = -(1 << (VALUE_WIDTH - 1));

  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  typedef struct packed {
    val_t in_zero;
    val_t in_one;
  } in_data_t;

  typedef struct packed {
    val_t out_zero;
    val_t out_one;
  } out_data_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_L1_ROW0    = 3'd0,
    REG_L1_ROW1    = 3'd1,
    REG_L1_BIAS    = 3'd2,
    REG_L2_COL0    = 3'd3,
    REG_L2_COL1    = 3'd4,
    REG_L2_BIAS    = 3'd5,
    REG_OUT_WEIGHT = 3'd6,
    REG_OUT_BIAS   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [47:0] l1_row0;
    logic [47:0] l1_row1;
    logic [47:0] l1_bias;
    logic [47:0] l2_col0;
    logic [47:0] l2_col1;
    logic [31:0] l2_bias;
    logic [63:0] out_weight;
    logic [31:0] out_bias;
  } cfg_t;

  // demo network, each element value*4096 rounded
  localparam cfg_t CFG_RESET = '{
    l1_row0:    48'h0800_04CD_019A,
    l1_row1:    48'h099A_0666_0333,
    l1_bias:    48'h04CD_0333_019A,
    l2_col0:    48'h04CD_0333_019A,
    l2_col1:    48'h099A_0800_0666,
    l2_bias:    32'h0333_019A,
    out_weight: 64'h0666_0333_04CD_019A,
    out_bias:   32'h0333_019A
  };

endpackage

FILE: design/mlp_fwd_cfg.sv
// mlp_fwd_cfg: weight and bias register file with demo reset values
// depends on mlp_fwd_pkg
`timescale 1ns / 1ps

module mlp_fwd_cfg (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [mlp_fwd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [mlp_fwd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  output mlp_fwd_pkg::cfg_t                        cfg
);

  mlp_fwd_pkg::cfg_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= mlp_fwd_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (mlp_fwd_pkg::cfg_reg_t'(cfg_index))
        mlp_fwd_pkg::REG_L1_ROW0:    regs_r.l1_row0    <= cfg_data[47:0];
        mlp_fwd_pkg::REG_L1_ROW1:    regs_r.l1_row1    <= cfg_data[47:0];
        mlp_fwd_pkg::REG_L1_BIAS:    regs_r.l1_bias    <= cfg_data[47:0];
        mlp_fwd_pkg::REG_L2_COL0:    regs_r.l2_col0    <= cfg_data[47:0];
        mlp_fwd_pkg::REG_L2_COL1:    regs_r.l2_col1    <= cfg_data[47:0];
        mlp_fwd_pkg::REG_L2_BIAS:    regs_r.l2_bias    <= cfg_data[31:0];
        mlp_fwd_pkg::REG_OUT_WEIGHT: regs_r.out_weight <= cfg_data[63:0];
        mlp_fwd_pkg::REG_OUT_BIAS:   regs_r.out_bias   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs_r;

  a_reset_demo: assert property (@(posedge clk)
    !rst_n |=> regs_r == mlp_fwd_pkg::CFG_RESET)
    else $error("register file not at demo values after reset");

  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == mlp_fwd_pkg::REG_OUT_WEIGHT |=>
      regs_r.out_weight == $past(cfg_data))
    else $error("output weight write lost");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> $stable(regs_r))
    else $error("registers changed without a write");

endmodule

FILE: design/mlp_fwd_layer.sv
// mlp_fwd_layer: one fully connected layer as three pipeline stages
// (multiply, sum and round, sigmoid or saturate); depends on mlp_fwd_pkg
`timescale 1ns / 1ps

module mlp_fwd_layer #(
  parameter int N_IN    = 2,
  parameter int N_OUT   = 3,
  parameter bit SIGMOID = 1'b1
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  mlp_fwd_pkg::val_t [N_IN-1:0]             in_vec,
  input  mlp_fwd_pkg::val_t [N_OUT-1:0][N_IN-1:0]  weight,
  input  mlp_fwd_pkg::val_t [N_OUT-1:0]            bias,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output mlp_fwd_pkg::val_t [N_OUT-1:0]            out_vec
);

  typedef logic signed [2*mlp_fwd_pkg::VALUE_WIDTH-1:0] prod_t;
  typedef logic signed [mlp_fwd_pkg::ACC_WIDTH-1:0]     acc_t;
  typedef logic signed [mlp_fwd_pkg::RND_WIDTH-1:0]     rnd_t;
  typedef logic        [mlp_fwd_pkg::RND_WIDTH-1:0]     mag_t;

  localparam acc_t ROUND_HALF = acc_t'(1 << (mlp_fwd_pkg::FRACTION_BITS - 1));

  function automatic mlp_fwd_pkg::val_t activate(input rnd_t r);
    mag_t a;
    mag_t y;
    if (SIGMOID) begin
      a = r[mlp_fwd_pkg::RND_WIDTH-1] ? mag_t'(-r) : mag_t'(r);
      if (a >= mag_t'(mlp_fwd_pkg::SIG_SAT)) begin
        y = mag_t'(mlp_fwd_pkg::SIG_ONE);
      end else if (a >= mag_t'(mlp_fwd_pkg::SIG_MID)) begin
        y = (a >> 5) + mag_t'(mlp_fwd_pkg::SIG_OFF_HI);
      end else if (a >= mag_t'(mlp_fwd_pkg::SIG_ONE)) begin
        y = (a >> 3) + mag_t'(mlp_fwd_pkg::SIG_OFF_MD);
      end else begin
        y = (a >> 2) + mag_t'(mlp_fwd_pkg::SIG_OFF_LO);
      end
      if (r[mlp_fwd_pkg::RND_WIDTH-1]) begin
        y = mag_t'(mlp_fwd_pkg::SIG_ONE) - y;
      end
      return mlp_fwd_pkg::val_t'(y);
    end else begin
      if (r > rnd_t'(mlp_fwd_pkg::VAL_MAX)) begin
        return mlp_fwd_pkg::val_t'(mlp_fwd_pkg::VAL_MAX);
      end else if (r < rnd_t'(mlp_fwd_pkg::VAL_MIN)) begin
        return mlp_fwd_pkg::val_t'(mlp_fwd_pkg::VAL_MIN);
      end else begin
        return mlp_fwd_pkg::val_t'(r);
      end
    end
  endfunction

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  prod_t [N_OUT-1:0][N_IN-1:0] prod_nxt, prod_r;
  acc_t  [N_OUT-1:0]           acc_sum;
  rnd_t  [N_OUT-1:0]           rnd_nxt, rnd_r;
  mlp_fwd_pkg::val_t [N_OUT-1:0] act_nxt, act_r;

  // a stage takes a new item when empty or when its item moves on
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    for (int o = 0; o < N_OUT; o++) begin
      for (int i = 0; i < N_IN; i++) begin
        prod_nxt[o][i] = prod_t'(in_vec[i]) * prod_t'(weight[o][i]);
      end
    end
  end

  always_comb begin
    for (int o = 0; o < N_OUT; o++) begin
      acc_sum[o] = acc_t'(bias[o]) <<< mlp_fwd_pkg::FRACTION_BITS;
      for (int i = 0; i < N_IN; i++) begin
        acc_sum[o] = acc_sum[o] + acc_t'(prod_r[o][i]);
      end
      // round half up, then floor shift
      rnd_nxt[o] = rnd_t'((acc_sum[o] + ROUND_HALF) >>> mlp_fwd_pkg::FRACTION_BITS);
    end
  end

  always_comb begin
    for (int o = 0; o < N_OUT; o++) begin
      act_nxt[o] = activate(rnd_r[o]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) prod_r <= prod_nxt;
    if (rdy2 && v1_r)     rnd_r  <= rnd_nxt;
    if (rdy3 && v2_r)     act_r  <= act_nxt;
  end

  assign out_valid = v3_r;
  assign out_vec   = act_r;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r)
    else $error("layer pipeline not empty after reset");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !rdy3 |=> v2_r && $stable(rnd_r))
    else $error("blocked stage dropped or changed its item");

  generate
    if (SIGMOID) begin : g_sig_chk
      for (genvar o = 0; o < N_OUT; o++) begin : g_unit
        a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
          v3_r |-> act_r[o] >= 0 &&
                   act_r[o] <= mlp_fwd_pkg::val_t'(mlp_fwd_pkg::SIG_ONE))
          else $error("sigmoid output out of range");
      end
    end
  endgenerate

endmodule

FILE: design/mlp_forward_2_3_2_2_core.sv
// mlp_forward_2_3_2_2_core: top level of the 2-3-2-2 perceptron forward pass
// depends on mlp_fwd_pkg, mlp_fwd_cfg and mlp_fwd_layer
`timescale 1ns / 1ps

// usage
//   input channel: in_valid / in_stall / in_data (in_zero, in_one, signed q4.12);
//   a transfer happens on a clock edge with in_valid high and in_stall low
//   result channel: out_valid / out_stall / out_data (out_zero, out_one, q4.12,
//   saturated to 16 bits), one result per input vector, in input order
//   config port: cfg_we / cfg_index / cfg_data, one register per write edge,
//   only while no vector is in flight; indexes follow the register list
//   pipeline: nine register stages, three per layer (multiply, sum and round,
//   activation)
//   throughput: one vector per cycle while out_stall is low; each layer has one
//   multiplier per weight
//   stall: a stalled result holds in the last stage; earlier stages keep filling
//   bubbles, and in_stall rises only once every stage is occupied
//   reset: synchronous, active low; empties the pipeline and reloads the
//   demo weights and biases

module mlp_forward_2_3_2_2_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  mlp_fwd_pkg::in_data_t                    in_data,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output mlp_fwd_pkg::out_data_t                   out_data,
  input  logic                                     cfg_we,
  input  logic [mlp_fwd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [mlp_fwd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  localparam int VW = mlp_fwd_pkg::VALUE_WIDTH;

  mlp_fwd_pkg::cfg_t cfg;

  // per-layer weights, biases and activations
  mlp_fwd_pkg::val_t [2:0][1:0] l1_w;
  mlp_fwd_pkg::val_t [2:0]      l1_b;
  mlp_fwd_pkg::val_t [1:0][2:0] l2_w;
  mlp_fwd_pkg::val_t [1:0]      l2_b;
  mlp_fwd_pkg::val_t [1:0][1:0] l3_w;
  mlp_fwd_pkg::val_t [1:0]      l3_b;

  mlp_fwd_pkg::val_t [1:0] x_vec;
  mlp_fwd_pkg::val_t [2:0] z1_vec;
  mlp_fwd_pkg::val_t [1:0] z2_vec;
  mlp_fwd_pkg::val_t [1:0] y_vec;

  // handshake between layers
  logic l1_in_ready, l1_out_valid, l2_in_ready;
  logic l2_out_valid, l3_in_ready;

  mlp_fwd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // unpack registers into weight matrices, element k at bits [k*VW +: VW]
  generate
    for (genvar j = 0; j < 3; j++) begin : g_l1
      assign l1_w[j][0] = cfg.l1_row0[j*VW +: VW];
      assign l1_w[j][1] = cfg.l1_row1[j*VW +: VW];
      assign l1_b[j]    = cfg.l1_bias[j*VW +: VW];
      assign l2_w[0][j] = cfg.l2_col0[j*VW +: VW];
      assign l2_w[1][j] = cfg.l2_col1[j*VW +: VW];
    end
    for (genvar k = 0; k < 2; k++) begin : g_l23
      assign l2_b[k]    = cfg.l2_bias[k*VW +: VW];
      // output weights are row major: row is the hidden unit
      assign l3_w[k][0] = cfg.out_weight[k*VW +: VW];
      assign l3_w[k][1] = cfg.out_weight[(2+k)*VW +: VW];
      assign l3_b[k]    = cfg.out_bias[k*VW +: VW];
    end
  endgenerate

  assign x_vec[0] = in_data.in_zero;
  assign x_vec[1] = in_data.in_one;

  // hidden layer one, 2 to 3 with sigmoid
  mlp_fwd_layer #(
    .N_IN    (2),
    .N_OUT   (3),
    .SIGMOID (1'b1)
  ) u_layer1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (l1_in_ready),
    .in_vec    (x_vec),
    .weight    (l1_w),
    .bias      (l1_b),
    .out_valid (l1_out_valid),
    .out_ready (l2_in_ready),
    .out_vec   (z1_vec)
  );

  // hidden layer two, 3 to 2 with sigmoid
  mlp_fwd_layer #(
    .N_IN    (3),
    .N_OUT   (2),
    .SIGMOID (1'b1)
  ) u_layer2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (l1_out_valid),
    .in_ready  (l2_in_ready),
    .in_vec    (z1_vec),
    .weight    (l2_w),
    .bias      (l2_b),
    .out_valid (l2_out_valid),
    .out_ready (l3_in_ready),
    .out_vec   (z2_vec)
  );

  // output layer, 2 to 2, saturated to the value range; its last stage is
  // the output register
  mlp_fwd_layer #(
    .N_IN    (2),
    .N_OUT   (2),
    .SIGMOID (1'b0)
  ) u_layer3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (l2_out_valid),
    .in_ready  (l3_in_ready),
    .in_vec    (z2_vec),
    .weight    (l3_w),
    .bias      (l3_b),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_vec   (y_vec)
  );

  assign in_stall          = !l1_in_ready;
  assign out_data.out_zero = y_vec[0];
  assign out_data.out_one  = y_vec[1];

endmodule
